// ----- design/ufr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_pkg
// shared types and constants of the disjoint-set store
// ----------------------------------------------------------------------------
package ufr_pkg;

	localparam int NODE_COUNT = 1024;
	localparam int NODE_W     = 10;
	localparam int ADDR_W     = $clog2(NODE_COUNT);
	localparam int RANK_W     = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
	localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(NODE_COUNT - 1);

	typedef enum logic [1:0] {
		CMD_MAKE  = 2'd0,
		CMD_FIND  = 2'd1,
		CMD_MERGE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_WALK,
		ST_COMPRESS,
		ST_LINK,
		ST_BUMP,
		ST_RESULT
	} state_t;

	// one memory word: rank above parent link
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [ADDR_W-1:0] parent;
	} entry_t;

	typedef struct packed {
		logic [NODE_W-1:0] root;
		logic              joined;
	} res_t;

	function automatic logic in_range(input logic [NODE_W-1:0] node);
		return (32'(node) < NODE_COUNT);
	endfunction

endpackage

// ----- design/ufr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ufr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/ufr_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_out_buf
// output register holding one finished item for the downstream side
// ----------------------------------------------------------------------------
module ufr_out_buf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  ufr_pkg::res_t              res,
	output logic                       slot_free,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ufr_pkg::NODE_W-1:0] root,
	output logic                       joined
);
	import ufr_pkg::*;

	logic valid_q;
	res_t data_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign root      = data_q.root;
	assign joined    = data_q.joined;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= res;
		end
	end

endmodule

// ----- design/ufr_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_engine
// command sequencer: clearing sweep, make-set write, root walk, path compression, link, rank bump
// ----------------------------------------------------------------------------
module ufr_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 command,
	input  logic [ufr_pkg::NODE_W-1:0] node_a,
	input  logic [ufr_pkg::NODE_W-1:0] node_b,
	input  logic                       slot_free,
	output logic                       res_push,
	output ufr_pkg::res_t              res,
	output logic                       wr_en,
	output logic [ufr_pkg::ADDR_W-1:0] wr_addr,
	output ufr_pkg::entry_t            wr_data,
	output logic                       rd_en,
	output logic [ufr_pkg::ADDR_W-1:0] rd_addr,
	input  ufr_pkg::entry_t            rd_data
);
	import ufr_pkg::*;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [1:0]        cmd_q, cmd_d;
	logic [NODE_W-1:0] a_q, a_d, b_q, b_d;
	logic [ADDR_W-1:0] cur_q, cur_d, start_q, start_d, top_q, top_d, ra_q, ra_d;
	logic [RANK_W-1:0] rank_a_q, rank_a_d, rank_b_q, rank_b_d;
	logic              phase_q, phase_d;
	res_t              res_q, res_d;

	// link decision for merge; top_q holds the second root then
	logic              a_wins;
	logic [ADDR_W-1:0] hi_node, lo_node;
	logic [RANK_W-1:0] hi_rank, lo_rank;

	assign a_wins  = !(rank_a_q < rank_b_q);
	assign hi_node = a_wins ? ra_q : top_q;
	assign lo_node = a_wins ? top_q : ra_q;
	assign hi_rank = a_wins ? rank_a_q : rank_b_q;
	assign lo_rank = a_wins ? rank_b_q : rank_a_q;

	assign res = res_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd_d    = cmd_q;
		a_d      = a_q;
		b_d      = b_q;
		cur_d    = cur_q;
		start_d  = start_q;
		top_d    = top_q;
		ra_d     = ra_q;
		rank_a_d = rank_a_q;
		rank_b_d = rank_b_q;
		phase_d  = phase_q;
		res_d    = res_q;
		in_ready = 1'b0;
		res_push = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		rd_en    = 1'b0;
		rd_addr  = '0;

		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_data = '{rank: '0, parent: cnt_q};
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == LAST_NODE) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_d   = command;
					a_d     = node_a;
					b_d     = node_b;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				res_d.root   = a_q;
				res_d.joined = 1'b0;
				state_d      = ST_RESULT;
				case (cmd_q) inside
					CMD_MAKE: begin
						if (in_range(a_q)) begin
							wr_en   = 1'b1;
							wr_addr = ADDR_W'(a_q);
							wr_data = '{rank: '0, parent: ADDR_W'(a_q)};
						end
					end
					CMD_FIND, CMD_MERGE: begin
						if (in_range(a_q) && (cmd_q == CMD_FIND || in_range(b_q))) begin
							rd_en   = 1'b1;
							rd_addr = ADDR_W'(a_q);
							cur_d   = ADDR_W'(a_q);
							start_d = ADDR_W'(a_q);
							phase_d = 1'b0;
							state_d = ST_WALK;
						end
					end
					default: ;
				endcase
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (rd_data.parent == cur_q) begin
					// root reached, restart at the start node to compress
					top_d = cur_q;
					if (!phase_q) begin
						rank_a_d = rd_data.rank;
					end else begin
						rank_b_d = rd_data.rank;
					end
					rd_addr = start_q;
					cur_d   = start_q;
					state_d = ST_COMPRESS;
				end else begin
					rd_addr = rd_data.parent;
					cur_d   = rd_data.parent;
				end
			end
			ST_COMPRESS: begin
				if (cur_q != top_q) begin
					// repoint this node, fetch the next one in the same cycle
					wr_en   = 1'b1;
					wr_addr = cur_q;
					wr_data = '{rank: rd_data.rank, parent: top_q};
					rd_en   = 1'b1;
					rd_addr = rd_data.parent;
					cur_d   = rd_data.parent;
				end else if (cmd_q == CMD_FIND) begin
					res_d.root   = NODE_W'(top_q);
					res_d.joined = 1'b0;
					state_d      = ST_RESULT;
				end else if (!phase_q) begin
					ra_d    = top_q;
					phase_d = 1'b1;
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(b_q);
					cur_d   = ADDR_W'(b_q);
					start_d = ADDR_W'(b_q);
					state_d = ST_WALK;
				end else if (top_q == ra_q) begin
					res_d.root   = NODE_W'(ra_q);
					res_d.joined = 1'b0;
					state_d      = ST_RESULT;
				end else begin
					state_d = ST_LINK;
				end
			end
			ST_LINK: begin
				wr_en        = 1'b1;
				wr_addr      = lo_node;
				wr_data      = '{rank: lo_rank, parent: hi_node};
				res_d.root   = NODE_W'(hi_node);
				res_d.joined = 1'b1;
				if (rank_a_q == rank_b_q && hi_rank != RANK_MAX) begin
					state_d = ST_BUMP;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_BUMP: begin
				wr_en   = 1'b1;
				wr_addr = hi_node;
				wr_data = '{rank: RANK_W'(hi_rank + 1'b1), parent: hi_node};
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (slot_free) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		a_q      <= a_d;
		b_q      <= b_d;
		cur_q    <= cur_d;
		start_q  <= start_d;
		top_q    <= top_d;
		ra_q     <= ra_d;
		rank_a_q <= rank_a_d;
		rank_b_q <= rank_b_d;
		res_q    <= res_d;
	end

endmodule

// ----- design/union_find_by_rank_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_by_rank_top
// disjoint-set store with union by rank and path compression
// ----------------------------------------------------------------------------
// order of states: make-set and ignored items go from dispatch to the result;
//   find walks the links from node_a to its root, then rewalks them to compress;
//   merge does so for node_a and node_b, then a link and, on a rank tie, a bump
// throughput: one item at a time, the next accepted in the cycle after the push
//   of a result; each walk or compression step is one dependent ram read
// reset: a clearing pass over all NODE_COUNT (1024) entries rewrites each to
//   parent self, rank zero; in_ready stays low until it ends
// ----------------------------------------------------------------------------
module union_find_by_rank_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 command,
	input  logic [ufr_pkg::NODE_W-1:0] node_a,
	input  logic [ufr_pkg::NODE_W-1:0] node_b,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ufr_pkg::NODE_W-1:0] root,
	output logic                       joined
);
	import ufr_pkg::*;

	// engine to output register
	logic slot_free;
	logic res_push;
	res_t res;

	// memory ports, one word per node holds rank and parent link
	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	entry_t                    wr_data;
	logic                      rd_en;
	logic [ADDR_W-1:0]         rd_addr;
	logic [$bits(entry_t)-1:0] rd_word;

	// sequencer: walks to the root, then rewalks the path writing the root
	// into each node; merge runs two finds, then links distinct roots and bumps a tied rank below RANK_MAX
	ufr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.node_a    (node_a),
		.node_b    (node_b),
		.slot_free (slot_free),
		.res_push  (res_push),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (entry_t'(rd_word))
	);

	// node table, read data registered
	ufr_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (NODE_COUNT)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	// finished item waits here so the engine can take the next item
	ufr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.root      (root),
		.joined    (joined)
	);

endmodule
